/* sv/dbd_pkg.sv */
// Package for the days-between-dates block: field widths, item types and calendar tables.
package dbd_pkg;

  localparam int unsigned DAY_W     = 5;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned COUNT_W   = 22;
  localparam int unsigned DAYNUM_W  = 23;
  localparam int unsigned DAYOFF_W  = 9;
  localparam int unsigned DEF_MAX_YEAR = 9999;

  // Division by 100 as a multiply by a scaled reciprocal, exact for all 14-bit values.
  localparam int unsigned DIV100_MUL = 5243;
  localparam int unsigned DIV100_SH  = 19;
  localparam int unsigned RECIP_W    = YEAR_W + 13;
  localparam int unsigned QUOT_W     = RECIP_W - DIV100_SH;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Month codes used by the tables.
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } dbd_date_t;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               count_end_day;
  } dbd_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] day_count;
    logic               date_error;
  } dbd_out_t;

  // Length of a month in a common year; zero for a code that is no month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC:            len = 5'd31;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      MONTH_FEB:                                  len = 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // Days in the common year before the first of the month.
  function automatic logic [DAYOFF_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DAYOFF_W-1:0] off;
    unique case (m)
      MONTH_JAN: off = 9'd0;
      MONTH_FEB: off = 9'd31;
      MONTH_MAR: off = 9'd59;
      MONTH_APR: off = 9'd90;
      MONTH_MAY: off = 9'd120;
      MONTH_JUN: off = 9'd151;
      MONTH_JUL: off = 9'd181;
      MONTH_AUG: off = 9'd212;
      MONTH_SEP: off = 9'd243;
      MONTH_OCT: off = 9'd273;
      MONTH_NOV: off = 9'd304;
      MONTH_DEC: off = 9'd334;
      default:   off = '0;
    endcase
    return off;
  endfunction

endpackage

/* sv/dbd_date.sv */
// Date unit: checks one date and converts it to a day number (0001-01-01 is day 1).
module dbd_date #(
  parameter int unsigned MAX_YEAR = dbd_pkg::DEF_MAX_YEAR
) (
  input  dbd_pkg::dbd_date_t              date_i,
  output logic                            valid_o,
  output logic [dbd_pkg::DAYNUM_W-1:0]    day_num_o
);
  import dbd_pkg::*;

  localparam logic [YEAR_W+1:0] MaxYearC = (YEAR_W + 2)'(MAX_YEAR);

  logic [YEAR_W-1:0]  prev_year;
  logic [RECIP_W-1:0] year_prod;
  logic [RECIP_W-1:0] prev_prod;
  logic [QUOT_W-1:0]  year_q100;
  logic [QUOT_W-1:0]  prev_q100;
  logic [YEAR_W-1:0]  year_r100;
  logic               leap;
  logic [DAY_W-1:0]   len;
  logic               year_ok;
  logic               month_ok;
  logic               day_ok;

  // Quotients by 100 of the year and of the year before it.
  assign prev_year = date_i.year - YEAR_W'(1);
  assign year_prod = RECIP_W'(date_i.year) * RECIP_W'(DIV100_MUL);
  assign prev_prod = RECIP_W'(prev_year) * RECIP_W'(DIV100_MUL);
  assign year_q100 = year_prod[RECIP_W-1:DIV100_SH];
  assign prev_q100 = prev_prod[RECIP_W-1:DIV100_SH];
  assign year_r100 = date_i.year - YEAR_W'(year_q100) * YEAR_W'(100);

  // Leap when divisible by 4, except centuries that are not divisible by 400.
  assign leap = (date_i.year[1:0] == 2'b00) &&
                ((year_r100 != '0) || (year_q100[1:0] == 2'b00));

  // Range checks on year, month and day.
  assign year_ok  = (date_i.year != '0) && ({2'b00, date_i.year} <= MaxYearC);
  assign month_ok = (date_i.month != '0) && (date_i.month <= MONTH_DEC);
  assign len      = (date_i.month == MONTH_FEB && leap) ? 5'd29 : month_len(date_i.month);
  assign day_ok   = (date_i.day != '0) && (date_i.day <= len);
  assign valid_o  = year_ok && month_ok && day_ok;

  // Closed-form day number from the completed years, the month offset and the day.
  always_comb begin
    day_num_o = DAYNUM_W'(prev_year) * DAYNUM_W'(365)
              + DAYNUM_W'(prev_year[YEAR_W-1:2])
              - DAYNUM_W'(prev_q100)
              + DAYNUM_W'(prev_q100[QUOT_W-1:2])
              + DAYNUM_W'(days_before(date_i.month))
              + DAYNUM_W'(leap && (date_i.month > MONTH_FEB))
              + DAYNUM_W'(date_i.day);
  end

endmodule

/* sv/days_between_dates_core.sv */
// Top level of the days-between-dates block: input register, two date units, result register.
// An item is taken at every clock edge where start is high; busy never rises, so items
// may follow one another in every cycle. The result for an item appears on result_o with
// done_o high for exactly one cycle, starting at the clock edge after the item was taken,
// and is captured at the edge after that; it must be taken then because the block cannot
// be stalled. The latency is fixed by the input register and the result register around
// the date conversion. day_count is the number of
// days from the first date to the second, zero when the first is not earlier, plus one when
// count_end_day is set and the count is nonzero; it saturates at the top of its 22 bits.
// An invalid day, month or year in either date raises date_error with a zero count.
module days_between_dates_core #(
  parameter int unsigned MAX_YEAR = dbd_pkg::DEF_MAX_YEAR
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dbd_pkg::dbd_in_t  in_item_i,
  output logic              done_o,
  output dbd_pkg::dbd_out_t result_o
);
  import dbd_pkg::*;

  logic                start_q;
  dbd_in_t             item_q;
  logic                done_q;
  dbd_out_t            result_q;
  dbd_out_t            result_d;
  dbd_date_t           first_date;
  dbd_date_t           second_date;
  logic                first_ok;
  logic                second_ok;
  logic [DAYNUM_W-1:0] first_num;
  logic [DAYNUM_W-1:0] second_num;
  logic [DAYNUM_W-1:0] diff;
  logic [DAYNUM_W:0]   count_full;

  // The block takes an item in every cycle.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= in_item_i;
    end
  end

  assign first_date  = '{day: item_q.start_day, month: item_q.start_month,
                         year: item_q.start_year};
  assign second_date = '{day: item_q.end_day, month: item_q.end_month,
                         year: item_q.end_year};

  dbd_date #(.MAX_YEAR(MAX_YEAR)) u_first (
    .date_i   (first_date),
    .valid_o  (first_ok),
    .day_num_o(first_num)
  );

  dbd_date #(.MAX_YEAR(MAX_YEAR)) u_second (
    .date_i   (second_date),
    .valid_o  (second_ok),
    .day_num_o(second_num)
  );

  // Difference of day numbers, end-day adjustment and saturation.
  always_comb begin
    diff       = second_num - first_num;
    count_full = {1'b0, diff} + (DAYNUM_W + 1)'(item_q.count_end_day);
    result_d   = '{day_count: '0, date_error: 1'b0};
    if (!(first_ok && second_ok)) begin
      result_d.date_error = 1'b1;
    end else if (first_num < second_num) begin
      if (count_full > (DAYNUM_W + 1)'(COUNT_MAX)) begin
        result_d.day_count = COUNT_MAX;
      end else begin
        result_d.day_count = count_full[COUNT_W-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

/* dv/days_between_dates_checker.sv */
// Checker for the days-between-dates block: predicts each result and compares it with the DUT.
`timescale 1ns / 1ps
module days_between_dates_checker #(
  parameter int unsigned MAX_YEAR = dbd_pkg::DEF_MAX_YEAR
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  dbd_pkg::dbd_in_t  in_item_i,
  input  logic              done_i,
  input  dbd_pkg::dbd_out_t result_i,
  output int unsigned       pending_o,
  output int unsigned       mismatch_cnt_o,
  output int unsigned       checked_cnt_o,
  output int unsigned       invalid_cnt_o
);
  import dbd_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned COUNT_SAT   = (1 << COUNT_W) - 1;

  // Expected results of accepted items, oldest first.
  dbd_out_t span_q[$];
  dbd_out_t want;
  logic     field_bad;

  initial begin
    pending_o      = 0;
    mismatch_cnt_o = 0;
    checked_cnt_o  = 0;
    invalid_cnt_o  = 0;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Days in month m of year y; zero when m is no month.
  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
      MONTH_AUG, MONTH_OCT, MONTH_DEC:            n = 31;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 30;
      MONTH_FEB:                                  n = is_leap_year(y) ? 29 : 28;
      default:                                    n = 0;
    endcase
    return n;
  endfunction

  function automatic bit date_valid(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    if (y == 0 || y > MAX_YEAR) return 1'b0;
    return (d >= 1) && (d <= month_days(m, y));
  endfunction

  // Serial day of a valid date, counting 1 Jan of year 1 as day 1.
  function automatic int unsigned serial_day(input int unsigned d, input int unsigned m,
                                             input int unsigned y);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned mm = 1; mm < m; mm++) n += month_days(mm, y);
    return n + d;
  endfunction

  // Expected result for one input item.
  function automatic dbd_out_t predict_span(input dbd_in_t it);
    dbd_out_t    r;
    int unsigned a;
    int unsigned b;
    int unsigned n;
    r = '0;
    if (!date_valid(it.start_day, it.start_month, it.start_year) ||
        !date_valid(it.end_day, it.end_month, it.end_year)) begin
      r.date_error = 1'b1;
      return r;
    end
    a = serial_day(it.start_day, it.start_month, it.start_year);
    b = serial_day(it.end_day, it.end_month, it.end_year);
    n = 0;
    if (a < b) begin
      n = b - a;
      if (it.count_end_day) n += 1;
    end
    if (n > COUNT_SAT) n = COUNT_SAT;
    r.day_count = n[COUNT_W-1:0];
    return r;
  endfunction

  // Compare results first, then record the item taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_i) begin
        if (span_q.size() == 0) begin
          if (mismatch_cnt_o < MAX_REPORTS)
            $display("%0t: result with nothing expected: count %0d error %0b",
                     $realtime, result_i.day_count, result_i.date_error);
          mismatch_cnt_o++;
        end else begin
          want = span_q.pop_front();
          checked_cnt_o++;
          if (want.date_error) invalid_cnt_o++;
          field_bad = (result_i.day_count !== want.day_count) ||
                      (result_i.date_error !== want.date_error);
          if (field_bad) begin
            if (mismatch_cnt_o < MAX_REPORTS)
              $display("%0t: mismatch: count exp %0d got %0d, error exp %0b got %0b",
                       $realtime, want.day_count, result_i.day_count,
                       want.date_error, result_i.date_error);
            mismatch_cnt_o++;
          end
        end
      end
      if (start_i && !busy_i) span_q.push_back(predict_span(in_item_i));
      pending_o = span_q.size();
    end
  end

endmodule

/* dv/days_between_dates_core_tb.sv */
// Testbench top for the days-between-dates block: clock, reset, item stimulus and verdict.
`timescale 1ns / 1ps
module days_between_dates_core_tb;
  import dbd_pkg::*;

  localparam int unsigned N_RANDOM    = 2000;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_GAP     = 19;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  dbd_in_t     in_item = '0;
  logic        busy;
  logic        done;
  dbd_out_t    result;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned invalid;
  int unsigned sent       = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned burst_left = 0;

  days_between_dates_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .in_item_i(in_item),
    .done_o   (done),
    .result_o (result)
  );

  days_between_dates_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .in_item_i     (in_item),
    .done_i        (done),
    .result_i      (result),
    .pending_o     (pending),
    .mismatch_cnt_o(mismatches),
    .checked_cnt_o (checked),
    .invalid_cnt_o (invalid)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_cnt, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic dbd_date_t mk_date(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
    dbd_date_t r;
    r.day   = d[DAY_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.year  = y[YEAR_W-1:0];
    return r;
  endfunction

  function automatic dbd_in_t pair_item(input dbd_date_t a, input dbd_date_t b,
                                        input logic inc);
    dbd_in_t it;
    it.start_day     = a.day;
    it.start_month   = a.month;
    it.start_year    = a.year;
    it.end_day       = b.day;
    it.end_month     = b.month;
    it.end_year      = b.year;
    it.count_end_day = inc;
    return it;
  endfunction

  // A mostly valid date in year y; 29 February is tried in any year now and then.
  function automatic dbd_date_t rand_date_in(input int unsigned y);
    int unsigned m;
    int unsigned len;
    m   = $urandom_range(1, 12);
    len = month_len(m[MONTH_W-1:0]);
    if (m == MONTH_FEB && $urandom_range(0, 3) == 0) len = 29;
    return mk_date($urandom_range(1, len), m, y);
  endfunction

  // Random item: mostly valid pairs, far apart, close or equal, plus broken and raw items.
  function automatic dbd_in_t next_random_item();
    int unsigned sel;
    int unsigned y;
    dbd_date_t   a;
    dbd_date_t   b;
    dbd_in_t     it;
    logic [63:0] raw;
    sel = $urandom_range(0, 19);
    y   = $urandom_range(1, 9999);
    a   = rand_date_in(y);
    if (sel < 9) begin
      b = rand_date_in($urandom_range(1, 9999));
    end else if (sel < 14) begin
      y = y + $urandom_range(0, 1);
      if (y > 9999) y = 9999;
      b = rand_date_in(y);
    end else if (sel < 16) begin
      b = a;
    end else begin
      b = rand_date_in($urandom_range(1, 9999));
    end
    it = pair_item(a, b, 1'($urandom_range(0, 1)));
    if (sel == 16 || sel == 17) begin
      raw = {$urandom(), $urandom()};
      it  = raw[$bits(dbd_in_t)-1:0];
    end else if (sel >= 18) begin
      // Push one field toward or out of its legal range; a day of 29 to 31 may still be legal.
      case ($urandom_range(0, 5))
        0: it.start_day   = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(29, 31));
        1: it.end_day     = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(29, 31));
        2: it.start_month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
        3: it.end_month   = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
        4: it.start_year  = $urandom_range(0, 1) ? 14'd0 : 14'($urandom_range(10000, 16383));
        default: it.end_year = $urandom_range(0, 1) ? 14'd0 :
                               14'($urandom_range(10000, 16383));
      endcase
    end
    return it;
  endfunction

  // Offer one item after a random gap, or back to back during a burst.
  task automatic send_item(input dbd_in_t it);
    int unsigned gap;
    logic [63:0] raw;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      gap        = 0;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
    end
    repeat (gap) begin
      @(negedge clk_i);
      raw     = {$urandom(), $urandom()};
      start   <= 1'b0;
      in_item <= raw[$bits(dbd_in_t)-1:0];
    end
    @(negedge clk_i);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  // Hold off the next item until every expected result has come back.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items: range ends, leap rules, ordering and each invalid field.
    send_item(pair_item(mk_date(1, MONTH_JAN, 1), mk_date(31, MONTH_DEC, 9999), 1'b0));
    send_item(pair_item(mk_date(1, MONTH_JAN, 1), mk_date(31, MONTH_DEC, 9999), 1'b1));
    send_item(pair_item(mk_date(31, MONTH_DEC, 9999), mk_date(1, MONTH_JAN, 1), 1'b1));
    send_item(pair_item(mk_date(15, MONTH_JUN, 2020), mk_date(15, MONTH_JUN, 2020), 1'b1));
    send_item(pair_item(mk_date(28, MONTH_FEB, 2023), mk_date(1, MONTH_MAR, 2023), 1'b0));
    send_item(pair_item(mk_date(28, MONTH_FEB, 2024), mk_date(1, MONTH_MAR, 2024), 1'b1));
    send_item(pair_item(mk_date(29, MONTH_FEB, 2024), mk_date(1, MONTH_JAN, 2025), 1'b0));
    send_item(pair_item(mk_date(29, MONTH_FEB, 2000), mk_date(29, MONTH_FEB, 2400), 1'b0));
    send_item(pair_item(mk_date(29, MONTH_FEB, 1900), mk_date(1, MONTH_MAR, 1900), 1'b0));
    send_item(pair_item(mk_date(1, MONTH_JAN, 2000), mk_date(29, MONTH_FEB, 2100), 1'b1));
    send_item(pair_item(mk_date(31, MONTH_DEC, 1999), mk_date(1, MONTH_JAN, 2000), 1'b1));
    send_item(pair_item(mk_date(31, MONTH_APR, 2021), mk_date(1, MONTH_MAY, 2021), 1'b0));
    send_item(pair_item(mk_date(0, MONTH_MAY, 2021), mk_date(1, MONTH_JUN, 2021), 1'b0));
    send_item(pair_item(mk_date(1, 0, 2021), mk_date(1, MONTH_JUN, 2021), 1'b0));
    send_item(pair_item(mk_date(1, MONTH_JAN, 2021), mk_date(1, 13, 2021), 1'b1));
    send_item(pair_item(mk_date(1, 15, 2021), mk_date(1, MONTH_JAN, 2022), 1'b0));
    send_item(pair_item(mk_date(1, MONTH_JAN, 0), mk_date(1, MONTH_JAN, 2), 1'b0));
    send_item(pair_item(mk_date(1, MONTH_JAN, 9999), mk_date(1, MONTH_JAN, 10000), 1'b0));
    send_item(pair_item(mk_date(1, MONTH_JAN, 16383), mk_date(1, MONTH_JAN, 2), 1'b1));
    send_item(pair_item(mk_date(31, MONTH_JAN, 9999), mk_date(30, MONTH_NOV, 9999), 1'b0));
    send_item(pair_item(mk_date(31, MONTH_DEC, 1), mk_date(1, MONTH_JAN, 2), 1'b1));
    send_item(pair_item(mk_date(31, 15, 16383), mk_date(31, 15, 16383), 1'b1));
    drain();

    // Random items, with one more full drain halfway through.
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain();
      send_item(next_random_item());
    end
    @(negedge clk_i);
    start <= 1'b0;

    // Let the last results arrive, then watch a few more cycles for stray strobes.
    wait (pending == 0);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items over %0d cycles; %0d results checked, %0d of them invalid dates.",
             sent, cycle_cnt, checked, invalid);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/dbd_pkg.sv
sv/dbd_date.sv
sv/days_between_dates_core.sv
dv/days_between_dates_checker.sv
dv/days_between_dates_core_tb.sv
